>>> hdl/maf_pkg.sv
package maf_pkg;

  // ring depth and field widths
  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;

  // derived widths
  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + POS_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // saturation limits on the quotient magnitude
  localparam logic [SUM_W-1:0] POS_LIM =
    {{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic [SUM_W-1:0] NEG_LIM =
    {{(SUM_W - SAMPLE_W){1'b0}}, 1'b1, {(SAMPLE_W - 1){1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

>>> hdl/moving_average_filter.sv
// moving_average_filter: sliding-window average of signed 32-bit samples
//
// input channel (in_valid / in_stall): one beat carries req_type and
// sample_value. req_type sample pushes the sample into a ring of the last
// window_length samples and yields one average_value beat; req_type clear
// zeroes the ring, the running sum and the write position and yields nothing.
// output channel (out_valid / out_stall): average_value is the running sum
// divided by the window length, truncated toward zero, saturated to 32 bits.
// config channel (cfg_valid / cfg_ready): writes window_length (1..64, zero
// acts as 1, larger values act as 64); write it while idle, then send a clear.
// sequence: a sample passes the update, sign, divide and fix steps before
// the next accept, and out_valid is registered as the fix step ends; the
// divide is radix-2 restoring, one quotient bit per cycle over the 38-bit
// sum. a clear is done in idle. in_stall stays high while a sample is in flight.
// reset: ring reads as zero, sum and position zero, window_length back to 16.
// if the receiver stalls, the result waits in the output register; the next
// sample is still accepted, and its result holds in the final step until the
// output register frees up.
module moving_average_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [maf_pkg::SAMPLE_W-1:0]  sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [maf_pkg::SAMPLE_W-1:0]  average_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [maf_pkg::CFG_W-1:0]     window_length
);
  import maf_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;

  logic [2:0]            state;
  logic [CFG_W-1:0]      win_len;
  logic [LEN_W-1:0]      eff_len;

  // ring storage, valid bits stand in for the zero fill
  logic [SAMPLE_W-1:0]   ring [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ring_vld;
  logic [SAMPLE_W-1:0]   rd_data;
  logic                  old_vld;
  logic                  ring_we;

  logic [POS_W-1:0]      write_position;
  logic [POS_W-1:0]      write_position_next;
  logic [LEN_W-1:0]      pos_inc;

  sample_t               sample_reg;
  sample_t               old_sample;
  sum_t                  running_sum;
  sum_t                  running_sum_next;

  // divider datapath
  logic                  neg;
  logic [SUM_W-1:0]      quo;
  logic [LEN_W-1:0]      rem;
  logic [CNT_W-1:0]      cnt;
  logic [LEN_W:0]        rem_sh;
  logic                  rem_ge;
  logic [LEN_W-1:0]      rem_next;

  logic [SAMPLE_W-1:0]   result;
  logic                  in_acc;
  logic                  out_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign ring_we   = (state == ST_UPD);

  // length clamp: zero acts as one, anything above the ring depth saturates
  always_comb begin
    if (win_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(win_len) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(win_len);
    end
  end

  // position advance, wraps at the window length
  always_comb begin
    pos_inc = LEN_W'(write_position) + LEN_W'(1);
    if (pos_inc >= eff_len) begin
      write_position_next = '0;
    end else begin
      write_position_next = POS_W'(pos_inc);
    end
  end

  // entries never written since the last clear read as zero
  assign old_sample       = old_vld ? sample_t'(rd_data) : '0;
  assign running_sum_next = running_sum + SUM_W'(sample_reg) - SUM_W'(old_sample);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, eff_len});
  assign rem_next = rem_ge ? LEN_W'(rem_sh - {1'b0, eff_len}) : LEN_W'(rem_sh);

  // sign restore and 32-bit saturation
  always_comb begin
    if (neg) begin
      result = (quo > NEG_LIM) ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : -quo[SAMPLE_W-1:0];
    end else begin
      result = (quo > POS_LIM) ? {1'b0, {(SAMPLE_W - 1){1'b1}}} : quo[SAMPLE_W-1:0];
    end
  end

  // ring memory: one write port, one registered read at the write position
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_position] <= sample_reg;
    end
    rd_data <= ring[write_position];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win_len <= window_length;
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ring_vld       <= '0;
      running_sum    <= '0;
      write_position <= '0;
      cnt            <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (req_type == REQ_CLEAR) begin
              ring_vld       <= '0;
              running_sum    <= '0;
              write_position <= '0;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          running_sum              <= running_sum_next;
          ring_vld[write_position] <= 1'b1;
          write_position           <= write_position_next;
          state                    <= ST_ABS;
        end
        ST_ABS: begin
          cnt   <= CNT_W'(SUM_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_FIX;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_FIX: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_reg <= sample_t'(sample_value);
      old_vld    <= ring_vld[write_position];
    end
    if (state == ST_ABS) begin
      // divide the magnitude, fix the sign afterwards
      neg <= running_sum[SUM_W-1];
      quo <= running_sum[SUM_W-1] ? -running_sum : running_sum;
      rem <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_next;
      quo <= {quo[SUM_W-2:0], rem_ge};
    end
  end

  // output register parts the divider from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIX && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIX && out_free) begin
      average_value <= result;
    end
  end

`ifndef SYNTHESIS
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && req_type == REQ_SAMPLE |=> state == ST_UPD)
    else $error("accepted sample did not start the update step");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    in_acc && req_type == REQ_CLEAR |=>
      running_sum == '0 && write_position == '0 && ring_vld == '0 && state == ST_IDLE)
    else $error("clear left filter state behind");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt < CNT_W'(SUM_W))
    else $error("divider step count out of range");

  a_out_from_fix: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIX)
    else $error("result shown without finishing a division");
`endif

endmodule
